FILE: hw/rtl/pjsg_pkg.sv
// ----------------------------------------------------------------------------
// pjsg_pkg
// Shared types and constants of the progressive jittered sample generator.
// ----------------------------------------------------------------------------
`default_nettype none

package pjsg_pkg;

    localparam int JIT_W    = 24;   // jitter fraction width
    localparam int OUT_W    = 24;   // emitted coordinate width
    localparam int IDX_W    = 12;   // emitted sample index width
    localparam int LVL_W    = 4;    // level counter width
    localparam int CFG_W    = 3;    // level_count register width
    localparam int S_DATA_W = 152;  // six jitters and swap_choice, byte padded
    localparam int M_DATA_W = 64;   // index and two coordinates, byte padded

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [CFG_W-1:0] LEVEL_COUNT_RST = 3'd3;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    typedef struct packed {
        logic             start;   // job emits sample zero only
        logic [LVL_W-1:0] k;       // level of the old sample
        logic [1:0]       phase;   // child being produced
        logic             done;    // final sample of the set at end of job
        logic             s_zero;  // old sample is entry zero
        logic             last;    // this phase ends the job
    } job_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pjsg_ram.sv
// ----------------------------------------------------------------------------
// pjsg_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pjsg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/pjsg_child.sv
// ----------------------------------------------------------------------------
// pjsg_child
// Child sample datapath: cell and half-bit slicing, jitter placement, index.
// ----------------------------------------------------------------------------
`default_nettype none

module pjsg_child #(
    parameter int COORD_BITS = 24,
    parameter int AW         = 12
) (
    input  wire logic [COORD_BITS-1:0]      old_x,
    input  wire logic [COORD_BITS-1:0]      old_y,
    input  wire logic [pjsg_pkg::JIT_W-1:0] jit_x,
    input  wire logic [pjsg_pkg::JIT_W-1:0] jit_y,
    input  wire logic                       swap,
    input  wire logic [AW-1:0]              old_idx,
    input  wire pjsg_pkg::job_t             job,
    output logic      [COORD_BITS-1:0]      new_x,
    output logic      [COORD_BITS-1:0]      new_y,
    output logic      [AW-1:0]              new_idx
);

    localparam int C = COORD_BITS;

    function automatic logic [C-1:0] jit_align(input logic [pjsg_pkg::JIT_W-1:0] r);
        logic [C+pjsg_pkg::JIT_W-1:0] t;
        t = {r, {C{1'b0}}};
        return t[C+pjsg_pkg::JIT_W-1:pjsg_pkg::JIT_W];
    endfunction

    logic [C-1:0] high_mask;
    logic [C-1:0] half_pos;
    logic [C-1:0] jx_term;
    logic [C-1:0] jy_term;
    logic         xh;
    logic         yh;
    logic         hx;
    logic         hy;
    logic [1:0]   child_no;

    always_comb begin
        high_mask = ~({C{1'b1}} >> job.k);
        half_pos  = {1'b1, {(C-1){1'b0}}} >> job.k;
        jx_term   = (jit_align(jit_x) >> job.k) >> 1;
        jy_term   = (jit_align(jit_y) >> job.k) >> 1;
        xh        = ~(|(old_x & half_pos));
        yh        = ~(|(old_y & half_pos));
        case (job.phase)
            pjsg_pkg::PH_FIRST: begin
                hx = xh;
                hy = yh;
            end
            pjsg_pkg::PH_SECOND: begin
                hx = swap ? ~xh : xh;
                hy = swap ? yh : ~yh;
            end
            pjsg_pkg::PH_THIRD: begin
                hx = swap ? xh : ~xh;
                hy = swap ? ~yh : yh;
            end
            default: begin
                hx = xh;
                hy = yh;
            end
        endcase
        new_x    = (old_x & high_mask) | (hx ? half_pos : '0) | jx_term;
        new_y    = (old_y & high_mask) | (hy ? half_pos : '0) | jy_term;
        child_no = job.phase + 2'd1;
        new_idx  = old_idx | (AW'(child_no) << {job.k, 1'b0});
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pjsg_ctrl.sv
// ----------------------------------------------------------------------------
// pjsg_ctrl
// Level register, generation state, item acceptance and child sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module pjsg_ctrl #(
    parameter int MAX_LEVELS = 6,
    parameter int AW         = 12
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [pjsg_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic                       s_tvalid,
    input  wire logic                       op,
    input  wire logic                       m_tready,
    output logic                            s_tready,
    output logic                            m_tvalid,
    output logic                            accept,
    output logic                            adv,
    output logic                            rd_en,
    output logic      [AW-1:0]              rd_addr,
    output logic      [AW-1:0]              job_s,
    output pjsg_pkg::job_t                  job
);

    localparam int LW = pjsg_pkg::LVL_W;

    logic [pjsg_pkg::CFG_W-1:0] level_count_reg;
    logic [LW-1:0]              level_reg, level_next;
    logic [AW-1:0]              ptr_reg, ptr_next;
    logic                       active_reg, active_next;
    logic                       busy_reg, busy_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [1:0]                 phase_reg, phase_next;
    logic                       start_reg, start_next;
    logic [LW-1:0]              k_reg, k_next;
    logic                       done_reg, done_next;
    logic                       s_zero_reg;
    logic [AW-1:0]              s_reg;

    logic [LW-1:0] lv;
    logic [LW-1:0] level_inc;
    logic [AW-1:0] m_size;
    logic [AW-1:0] s_cur;
    logic          wrap;
    logic          out_free;
    logic          last_ph;

    always_comb begin
        lv = ({1'b0, level_count_reg} > LW'(MAX_LEVELS)) ? LW'(MAX_LEVELS)
                                                         : LW'(level_count_reg);
        level_inc = level_reg + 1'b1;
        m_size    = AW'(1) << {level_reg, 1'b0};
        s_cur     = ptr_reg & (m_size - 1'b1);
        wrap      = (s_cur == m_size - 1'b1);
        out_free  = !m_tvalid_reg || m_tready;
        last_ph   = start_reg || (phase_reg == pjsg_pkg::PH_THIRD);
        adv       = busy_reg && out_free;
        s_tready  = !busy_reg || (adv && last_ph);
        accept    = s_tvalid && s_tready;

        level_next    = level_reg;
        ptr_next      = ptr_reg;
        active_next   = active_reg;
        busy_next     = busy_reg;
        phase_next    = phase_reg;
        start_next    = start_reg;
        k_next        = k_reg;
        done_next     = done_reg;
        m_tvalid_next = m_tvalid_reg;

        if (adv) begin
            m_tvalid_next = 1'b1;
            phase_next    = phase_reg + 2'd1;
            if (last_ph) begin
                busy_next = 1'b0;
            end
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (accept) begin
            phase_next = pjsg_pkg::PH_FIRST;
            if (op == pjsg_pkg::OP_START) begin
                level_next  = '0;
                ptr_next    = '0;
                active_next = (lv != '0);
                busy_next   = 1'b1;
                start_next  = 1'b1;
                done_next   = (lv == '0);
            end else if (active_reg) begin
                if (level_reg >= lv) begin
                    active_next = 1'b0;
                end else begin
                    busy_next  = 1'b1;
                    start_next = 1'b0;
                    k_next     = level_reg;
                    done_next  = 1'b0;
                    if (wrap) begin
                        ptr_next   = '0;
                        level_next = level_inc;
                        if (level_inc >= lv) begin
                            active_next = 1'b0;
                            done_next   = 1'b1;
                        end
                    end else begin
                        ptr_next = s_cur + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_count_reg <= pjsg_pkg::LEVEL_COUNT_RST;
            level_reg       <= '0;
            ptr_reg         <= '0;
            active_reg      <= 1'b0;
            busy_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            phase_reg       <= pjsg_pkg::PH_FIRST;
            start_reg       <= 1'b0;
            k_reg           <= '0;
            done_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                level_count_reg <= cfg_wdata;
            end
            level_reg    <= level_next;
            ptr_reg      <= ptr_next;
            active_reg   <= active_next;
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
            phase_reg    <= phase_next;
            start_reg    <= start_next;
            k_reg        <= k_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s_reg      <= s_cur;
            s_zero_reg <= (s_cur == '0);
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign rd_en      = accept && (op == pjsg_pkg::OP_STEP);
    assign rd_addr    = s_cur;
    assign job_s      = s_reg;
    assign job.start  = start_reg;
    assign job.k      = k_reg;
    assign job.phase  = phase_reg;
    assign job.done   = done_reg;
    assign job.s_zero = s_zero_reg;
    assign job.last   = last_ph;

endmodule

`default_nettype wire

FILE: hw/rtl/progressive_jittered_sample_generator.sv
// ----------------------------------------------------------------------------
// progressive_jittered_sample_generator
// Progressive jittered 2D sample set built in an on-chip sample store.
// ----------------------------------------------------------------------------
// A start item yields sample zero as one result item; a step item reads one
// old sample from the store when it is accepted and yields three children, one
// per cycle while the output is not stalled, through the store's single write
// port. The next item is taken in the cycle the last result of the current one
// is loaded into the output register; an item that yields nothing leaves the
// block idle. Sample zero is also held in registers and forwarded on reads of
// entry zero. The store needs no clearing pass after reset.
`default_nettype none

module progressive_jittered_sample_generator #(
    parameter int MAX_LEVELS = 6,
    parameter int COORD_BITS = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [pjsg_pkg::CFG_W-1:0]    cfg_wdata,   // level_count
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // jitter_first_x, jitter_first_y, jitter_second_x, jitter_second_y,
    // jitter_third_x, jitter_third_y, swap_choice
    input  wire logic [pjsg_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,     // op
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [pjsg_pkg::M_DATA_W-1:0] m_tdata,     // sample_index, coord_x, coord_y
    output logic                               m_tlast,     // last_in_run
    output logic                               m_tuser      // set_done
);

    localparam int C  = COORD_BITS;
    localparam int AW = 2 * MAX_LEVELS;
    localparam int JW = pjsg_pkg::JIT_W;
    localparam int OW = pjsg_pkg::OUT_W;
    localparam int IW = pjsg_pkg::IDX_W;

    function automatic logic [C-1:0] jit_align(input logic [JW-1:0] r);
        logic [C+JW-1:0] t;
        t = {r, {C{1'b0}}};
        return t[C+JW-1:JW];
    endfunction

    function automatic logic [OW-1:0] coord_out(input logic [C-1:0] v);
        logic [C+OW-1:0] t;
        t = {v, {OW{1'b0}}};
        return t[C+OW-1:C];
    endfunction

    logic           accept;
    logic           adv;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  job_s;
    pjsg_pkg::job_t job;

    logic [JW-1:0]  jfx_reg, jfy_reg, jsx_reg, jsy_reg, jtx_reg, jty_reg;
    logic           swap_reg;
    logic [C-1:0]   s0x_reg, s0y_reg;
    logic [2*C-1:0] rd_data;

    logic [C-1:0]   old_x, old_y;
    logic [JW-1:0]  jit_x, jit_y;
    logic [C-1:0]   new_x, new_y;
    logic [AW-1:0]  new_idx;
    logic [AW+IW-1:0] idx_ext;

    logic [IW-1:0]  m_idx_reg;
    logic [OW-1:0]  m_x_reg, m_y_reg;
    logic           m_last_reg, m_done_reg;

    pjsg_ctrl #(
        .MAX_LEVELS (MAX_LEVELS),
        .AW         (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .op        (s_tuser),
        .m_tready  (m_tready),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .accept    (accept),
        .adv       (adv),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .job_s     (job_s),
        .job       (job)
    );

    pjsg_ram #(
        .WIDTH (2 * C),
        .DEPTH (1 << AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (adv && !job.start),
        .wr_addr (new_idx),
        .wr_data ({new_y, new_x}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            jfx_reg  <= s_tdata[23:0];
            jfy_reg  <= s_tdata[47:24];
            jsx_reg  <= s_tdata[71:48];
            jsy_reg  <= s_tdata[95:72];
            jtx_reg  <= s_tdata[119:96];
            jty_reg  <= s_tdata[143:120];
            swap_reg <= s_tdata[144];
            if (s_tuser == pjsg_pkg::OP_START) begin
                s0x_reg <= jit_align(s_tdata[23:0]);
                s0y_reg <= jit_align(s_tdata[47:24]);
            end
        end
    end

    always_comb begin
        old_x = job.s_zero ? s0x_reg : rd_data[C-1:0];
        old_y = job.s_zero ? s0y_reg : rd_data[2*C-1:C];
        case (job.phase)
            pjsg_pkg::PH_FIRST: begin
                jit_x = jfx_reg;
                jit_y = jfy_reg;
            end
            pjsg_pkg::PH_SECOND: begin
                jit_x = jsx_reg;
                jit_y = jsy_reg;
            end
            default: begin
                jit_x = jtx_reg;
                jit_y = jty_reg;
            end
        endcase
    end

    pjsg_child #(
        .COORD_BITS (C),
        .AW         (AW)
    ) u_child (
        .old_x   (old_x),
        .old_y   (old_y),
        .jit_x   (jit_x),
        .jit_y   (jit_y),
        .swap    (swap_reg),
        .old_idx (job_s),
        .job     (job),
        .new_x   (new_x),
        .new_y   (new_y),
        .new_idx (new_idx)
    );

    assign idx_ext = {{IW{1'b0}}, new_idx};

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (job.start) begin
                m_idx_reg <= '0;
                m_x_reg   <= coord_out(s0x_reg);
                m_y_reg   <= coord_out(s0y_reg);
            end else begin
                m_idx_reg <= idx_ext[IW-1:0];
                m_x_reg   <= coord_out(new_x);
                m_y_reg   <= coord_out(new_y);
            end
            m_last_reg <= job.last;
            m_done_reg <= job.last && job.done;
        end
    end

    assign m_tdata = {4'b0, m_y_reg, m_x_reg, m_idx_reg};
    assign m_tlast = m_last_reg;
    assign m_tuser = m_done_reg;

endmodule

`default_nettype wire

FILE: verif/tb_progressive_jittered_sample_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_progressive_jittered_sample_generator
// Self-checking bench: a directed table, then random set builds, each emitted
// sample checked against the row's expectation or an in-bench model of the refinement.
// ----------------------------------------------------------------------------
module tb_progressive_jittered_sample_generator;

    localparam int   IDX_W    = pjsg_pkg::IDX_W;
    localparam int   OUT_W    = pjsg_pkg::OUT_W;
    localparam int   JIT_W    = pjsg_pkg::JIT_W;
    localparam int   CFG_W    = pjsg_pkg::CFG_W;
    localparam int   S_DATA_W = pjsg_pkg::S_DATA_W;
    localparam int   M_DATA_W = pjsg_pkg::M_DATA_W;
    localparam logic OP_START = pjsg_pkg::OP_START;
    localparam logic OP_STEP  = pjsg_pkg::OP_STEP;

    localparam int MAX_LVL = 6;
    localparam int STORE_N = 1 << (2 * MAX_LVL);

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic             last;
        logic             done;
    } sample_t;

    typedef struct packed {
        logic             cfg_en;
        logic [CFG_W-1:0] cfg_val;
        logic             op;
        logic             swap;
        logic [JIT_W-1:0] jx;
        logic [JIT_W-1:0] jy;
        logic             typed;      // expectation given in the row
        logic             typed_hit;  // typed row yields one sample
        logic [OUT_W-1:0] tx;
        logic [OUT_W-1:0] ty;
        logic             tdone;
    } dir_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_we;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                m_tuser;

    // model state
    logic [OUT_W-1:0] pts_x [0:STORE_N-1];
    logic [OUT_W-1:0] pts_y [0:STORE_N-1];
    logic [CFG_W-1:0] lvl_cfg;
    int unsigned      lvl_now;
    int unsigned      next_old;
    bit               gen_on;
    sample_t          kids [0:2];

    sample_t  expected_samples [$];
    dir_row_t dir_rows [$];
    sample_t  got;
    int       err_count = 0;
    int       produced = 0;
    bit       gaps_on = 1'b1;
    bit       hold_req = 1'b0;
    bit       hold_sent = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    progressive_jittered_sample_generator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // Model of one accepted item; children land in kids[], count returned.
    function automatic int derive_samples(input logic op, input logic [S_DATA_W-1:0] d);
        int unsigned      lv, k, m, s, ci, cj, idx, hb, r;
        logic             xh, yh, fin;
        logic [2:0]       hx, hy;
        logic [JIT_W-1:0] jx, jy;
        lv = (lvl_cfg > MAX_LVL) ? MAX_LVL : lvl_cfg;
        if (op == OP_START) begin
            pts_x[0] = d[0 +: JIT_W];
            pts_y[0] = d[JIT_W +: JIT_W];
            lvl_now  = 0;
            next_old = 0;
            gen_on   = (lv != 0);
            kids[0]  = {12'd0, d[0 +: JIT_W], d[JIT_W +: JIT_W], 1'b1, lv == 0};
            return 1;
        end
        if (!gen_on)
            return 0;
        if (lvl_now >= lv) begin
            gen_on = 1'b0;
            return 0;
        end
        k  = lvl_now;
        m  = 1 << (2 * k);
        s  = next_old & (m - 1);
        ci = pts_x[s] >> (OUT_W - k);
        cj = pts_y[s] >> (OUT_W - k);
        xh = ~pts_x[s][OUT_W-1-k];
        yh = ~pts_y[s][OUT_W-1-k];
        hx[0] = xh;
        hy[0] = yh;
        if (d[6*JIT_W])
            xh = ~xh;
        else
            yh = ~yh;
        hx[1] = xh;
        hy[1] = yh;
        hx[2] = ~xh;
        hy[2] = ~yh;
        fin = 1'b0;
        if (s + 1 == m) begin
            next_old = 0;
            lvl_now  = k + 1;
            if (lvl_now >= lv) begin
                gen_on = 1'b0;
                fin    = 1'b1;
            end
        end else begin
            next_old = s + 1;
        end
        for (r = 0; r < 3; r++) begin
            idx = (r + 1) * m + s;
            jx  = d[2*JIT_W*r +: JIT_W];
            jy  = d[2*JIT_W*r + JIT_W +: JIT_W];
            kids[r].idx = idx[IDX_W-1:0];
            hb = hx[r];
            kids[r].x = OUT_W'((ci << (OUT_W - k)) + (hb << (OUT_W - 1 - k))
                               + (jx >> (k + 1)));
            hb = hy[r];
            kids[r].y = OUT_W'((cj << (OUT_W - k)) + (hb << (OUT_W - 1 - k))
                               + (jy >> (k + 1)));
            kids[r].last = (r == 2);
            kids[r].done = (r == 2) && fin;
            pts_x[idx] = kids[r].x;
            pts_y[idx] = kids[r].y;
        end
        return 3;
    endfunction

    function automatic logic [JIT_W-1:0] pick_jitter();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return JIT_W'($urandom());
        endcase
    endfunction

    function automatic dir_row_t mk_row(input int cfg, input logic op,
                                        input logic [JIT_W-1:0] jx, input logic [JIT_W-1:0] jy,
                                        input logic swap, input int tn,
                                        input logic [OUT_W-1:0] tx, input logic [OUT_W-1:0] ty,
                                        input logic tdone);
        dir_row_t row;
        row.cfg_en    = (cfg >= 0);
        row.cfg_val   = cfg[CFG_W-1:0];
        row.op        = op;
        row.swap      = swap;
        row.jx        = jx;
        row.jy        = jy;
        row.typed     = (tn >= 0);
        row.typed_hit = (tn == 1);
        row.tx        = tx;
        row.ty        = ty;
        row.tdone     = tdone;
        return row;
    endfunction

    task automatic put_item(input logic op, input logic [S_DATA_W-1:0] d, input bit typed,
                            input bit typed_hit, input sample_t typed_smp);
        int n, i;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n = derive_samples(op, d);
        if (typed) begin
            if (typed_hit)
                expected_samples.push_back(typed_smp);
        end else begin
            for (i = 0; i < n; i++)
                expected_samples.push_back(kids[i]);
        end
        if (n > 0)
            produced++;
    endtask

    // Only while idle: wait out pending samples plus the no-result step cycle.
    task automatic set_levels(input logic [CFG_W-1:0] v);
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        lvl_cfg = v;
    endtask

    // stimulus
    initial begin
        dir_row_t         row;
        int               ri, lv, cl, kind, nsteps, i;
        logic             op;
        logic [JIT_W-1:0] j [0:5];
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= OP_START;
        s_tdata   <= '0;
        lvl_cfg   = pjsg_pkg::LEVEL_COUNT_RST;
        lvl_now   = 0;
        next_old  = 0;
        gen_on    = 1'b0;

        // step while idle, zero levels, clamped count, lowered/raised count,
        // start mid-run, jitter extremes
        dir_rows.push_back(mk_row(-1, OP_STEP,  24'h000000, 24'h000000, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(0,  OP_START, 24'hFFFFFF, 24'h000000, 0, 1,
                                  24'hFFFFFF, 24'h000000, 1));
        dir_rows.push_back(mk_row(-1, OP_STEP,  24'hFFFFFF, 24'hFFFFFF, 1, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(1,  OP_START, 24'h000000, 24'h000000, 0, 1,
                                  24'h000000, 24'h000000, 0));
        dir_rows.push_back(mk_row(-1, OP_STEP,  24'hFFFFFF, 24'hFFFFFF, 1, -1, 0, 0, 0));
        dir_rows.push_back(mk_row(-1, OP_STEP,  24'h123456, 24'h654321, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(2,  OP_START, 24'h800000, 24'h7FFFFF, 0, 1,
                                  24'h800000, 24'h7FFFFF, 0));
        dir_rows.push_back(mk_row(-1, OP_STEP,  24'h000000, 24'hFFFFFF, 0, -1, 0, 0, 0));
        dir_rows.push_back(mk_row(-1, OP_STEP,  24'hFFFFFF, 24'h000000, 1, -1, 0, 0, 0));
        dir_rows.push_back(mk_row(-1, OP_STEP,  24'hFFFFFF, 24'h000000, 0, -1, 0, 0, 0));
        dir_rows.push_back(mk_row(-1, OP_STEP,  24'h000000, 24'hFFFFFF, 1, -1, 0, 0, 0));
        dir_rows.push_back(mk_row(-1, OP_STEP,  24'hFFFFFF, 24'hFFFFFF, 0, -1, 0, 0, 0));
        dir_rows.push_back(mk_row(7,  OP_START, 24'h3C3C3C, 24'hC3C3C3, 1, 1,
                                  24'h3C3C3C, 24'hC3C3C3, 0));
        dir_rows.push_back(mk_row(-1, OP_STEP,  24'hAAAAAA, 24'h555555, 1, -1, 0, 0, 0));
        dir_rows.push_back(mk_row(-1, OP_STEP,  24'h555555, 24'hAAAAAA, 0, -1, 0, 0, 0));
        dir_rows.push_back(mk_row(1,  OP_STEP,  24'h111111, 24'h222222, 1, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(-1, OP_STEP,  24'h333333, 24'h444444, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(3,  OP_START, 24'h0F0F0F, 24'hF0F0F0, 0, 1,
                                  24'h0F0F0F, 24'hF0F0F0, 0));
        dir_rows.push_back(mk_row(-1, OP_STEP,  24'h7FFFFF, 24'h800000, 1, -1, 0, 0, 0));
        dir_rows.push_back(mk_row(-1, OP_STEP,  24'h000001, 24'hFFFFFE, 0, -1, 0, 0, 0));
        dir_rows.push_back(mk_row(-1, OP_START, 24'h000001, 24'hFFFFFE, 0, 1,
                                  24'h000001, 24'hFFFFFE, 0));
        dir_rows.push_back(mk_row(-1, OP_STEP,  24'hFEDCBA, 24'h012345, 1, -1, 0, 0, 0));
        dir_rows.push_back(mk_row(4,  OP_STEP,  24'h9ABCDE, 24'h13579B, 0, -1, 0, 0, 0));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (ri = 0; ri < dir_rows.size(); ri++) begin
            row = dir_rows[ri];
            if (row.cfg_en)
                set_levels(row.cfg_val);
            put_item(row.op, {7'd0, row.swap, row.jy, row.jx, row.jy, row.jx, row.jy, row.jx},
                     row.typed, row.typed_hit, {12'd0, row.tx, row.ty, 1'b1, row.tdone});
        end

        produced = 0;
        while (produced < 370) begin
            case ($urandom_range(0, 19))
                0:                  lv = 0;
                1, 2, 3, 4:         lv = 1;
                5, 6, 7, 8, 9:      lv = 2;
                10, 11, 12, 13, 14: lv = 3;
                15, 16:             lv = 4;
                17:                 lv = 5;
                18:                 lv = 6;
                default:            lv = 7;
            endcase
            kind = $urandom_range(0, 9);
            set_levels(lv[CFG_W-1:0]);
            cl = (lv > MAX_LVL) ? MAX_LVL : lv;
            if (kind == 0 && gen_on) begin
                nsteps = $urandom_range(1, 12);
            end else begin
                for (i = 0; i < 6; i++)
                    j[i] = pick_jitter();
                put_item(OP_START, {7'd0, 1'($urandom_range(0, 1)),
                                    j[5], j[4], j[3], j[2], j[1], j[0]}, 0, 0, '0);
                if (cl >= 5)
                    nsteps = $urandom_range(20, 110);
                else
                    nsteps = ((1 << (2 * cl)) - 1) / 3 + $urandom_range(0, 1);
                if (kind == 1)
                    nsteps = $urandom_range(0, nsteps);
            end
            for (i = 0; i < nsteps && produced < 370; i++) begin
                op = ($urandom_range(0, 32) == 0) ? OP_START : OP_STEP;
                for (ri = 0; ri < 6; ri++)
                    j[ri] = pick_jitter();
                put_item(op, {7'd0, 1'($urandom_range(0, 1)),
                              j[5], j[4], j[3], j[2], j[1], j[0]}, 0, 0, '0);
                if (produced >= 120 && !hold_sent) begin
                    hold_req  = 1'b1;
                    hold_sent = 1'b1;
                end
                if (produced >= 310)
                    gaps_on = 1'b0;
            end
        end

        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_count == 0)
            $display("PASS progressive_jittered_sample_generator");
        else
            $display("FAIL progressive_jittered_sample_generator");
        $finish;
    end

    // receiver: random stalls, one long hold-off
    initial begin
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (64) @(posedge aclk);
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[11:0], m_tdata[35:12], m_tdata[59:36], m_tlast, m_tuser};
            if (expected_samples.size() == 0) begin
                err_count++;
                if (err_count <= 200)
                    $display("%0t: unexpected item idx %0d x %h y %h last %b done %b",
                             $time, got.idx, got.x, got.y, got.last, got.done);
            end else begin
                if (got !== expected_samples[0]) begin
                    err_count++;
                    if (err_count <= 200)
                        $display({"%0t: expected idx %0d x %h y %h last %b done %b, ",
                                  "got idx %0d x %h y %h last %b done %b"},
                                 $time, expected_samples[0].idx, expected_samples[0].x,
                                 expected_samples[0].y, expected_samples[0].last,
                                 expected_samples[0].done, got.idx, got.x, got.y,
                                 got.last, got.done);
                end
                void'(expected_samples.pop_front());
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL progressive_jittered_sample_generator");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/pjsg_pkg.sv
hw/rtl/pjsg_ram.sv
hw/rtl/pjsg_child.sv
hw/rtl/pjsg_ctrl.sv
hw/rtl/progressive_jittered_sample_generator.sv
verif/tb_progressive_jittered_sample_generator.sv
